// ----- rtl/core/mwm_pkg.sv -----
// ============================================================================
// mwm_pkg
// Shared types and constants of the mecanum wheel mixer: field widths,
// direction codes, register indexes and the structs passed between stages.
// ============================================================================
package mwm_pkg;

    localparam int WHEELS     = 4;
    localparam int CMD_W      = 16;
    localparam int LIM_W      = 15;
    localparam int SUM_W      = CMD_W + 2;
    localparam int MAG_W      = SUM_W - 1;
    localparam int PROD_W     = MAG_W + LIM_W;
    localparam int QUO_W      = LIM_W;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = QUO_W / DIV_STEP;
    localparam int DIR_W      = 2;
    localparam int FIELD_W    = DIR_W + QUO_W;
    localparam int IDX_W      = 2;
    localparam int IN_W       = ((3 * CMD_W + 7) / 8) * 8;
    localparam int OUT_W      = ((WHEELS * FIELD_W + 7) / 8) * 8;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd999;

    typedef enum logic [DIR_W-1:0] {
        DIR_OFF = 2'd0,
        DIR_FWD = 2'd1,
        DIR_REV = 2'd2
    } dir_t;

    typedef enum logic [IDX_W-1:0] {
        CFG_COMMAND_LIMIT = 2'd0,
        CFG_DUTY_LIMIT    = 2'd1
    } cfg_idx_t;

    typedef logic signed [CMD_W-1:0] cmd_t;
    typedef logic [MAG_W-1:0]        mag_t;
    typedef logic [QUO_W-1:0]        quo_t;

    typedef struct packed {
        logic [WHEELS-1:0]     neg;
        mag_t [WHEELS-1:0]     mag;
        logic [LIM_W-1:0]      mult;
        mag_t                  divisor;
    } mwm_setup_t;

    typedef struct packed {
        logic [WHEELS-1:0]     neg;
        mag_t                  divisor;
        mag_t [WHEELS-1:0]     rem;
        quo_t [WHEELS-1:0]     low;
        quo_t [WHEELS-1:0]     quo;
    } mwm_div_t;

endpackage

// ----- rtl/core/mwm_front.sv -----
// ============================================================================
// mwm_front
// Three pipeline stages: command clamp, wheel sums with magnitudes, and peak
// search that picks the scale factor and divisor for each item.
// ============================================================================
module mwm_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mwm_pkg::IN_W-1:0]    in_data,
    input  logic [mwm_pkg::LIM_W-1:0]   command_limit,
    input  logic [mwm_pkg::LIM_W-1:0]   duty_limit,
    output logic                        out_valid,
    input  logic                        out_ready,
    output mwm_pkg::mwm_setup_t         out_data
);
    import mwm_pkg::*;

    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic                   ready1;
    logic                   ready2;
    logic                   ready3;
    cmd_t [2:0]             cmd_reg;
    cmd_t [2:0]             cmd_next;
    logic [WHEELS-1:0]      neg_reg;
    logic [WHEELS-1:0]      neg_next;
    mag_t [WHEELS-1:0]      mag_reg;
    mag_t [WHEELS-1:0]      mag_next;
    mwm_setup_t             setup_reg;
    mwm_setup_t             setup_next;

    assign ready3    = !v3_reg || out_ready;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign in_ready  = ready1;
    assign out_valid = v3_reg;
    assign out_data  = setup_reg;

    always_comb
    begin
        cmd_t lim_pos;
        cmd_t lim_neg;
        cmd_t x;
        lim_pos = $signed({1'b0, command_limit});
        lim_neg = -lim_pos;
        for (int i = 0; i < 3; i++)
        begin
            x = $signed(in_data[i*CMD_W +: CMD_W]);
            if (x > lim_pos)
            begin
                cmd_next[i] = lim_pos;
            end
            else if (x < lim_neg)
            begin
                cmd_next[i] = lim_neg;
            end
            else
            begin
                cmd_next[i] = x;
            end
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] f;
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] w [WHEELS];
        logic signed [SUM_W-1:0] a;
        f = {{(SUM_W-CMD_W){cmd_reg[0][CMD_W-1]}}, cmd_reg[0]};
        s = {{(SUM_W-CMD_W){cmd_reg[1][CMD_W-1]}}, cmd_reg[1]};
        t = {{(SUM_W-CMD_W){cmd_reg[2][CMD_W-1]}}, cmd_reg[2]};
        w[0] = f + s + t;
        w[1] = f - s - t;
        w[2] = f - s + t;
        w[3] = f + s - t;
        for (int i = 0; i < WHEELS; i++)
        begin
            neg_next[i] = w[i][SUM_W-1];
            a           = neg_next[i] ? -w[i] : w[i];
            mag_next[i] = a[MAG_W-1:0];
        end
    end

    always_comb
    begin
        mag_t peak01;
        mag_t peak23;
        mag_t peak;
        logic scale;
        peak01 = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        peak23 = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
        peak   = (peak01 > peak23) ? peak01 : peak23;
        scale  = peak > {{(MAG_W-LIM_W){1'b0}}, duty_limit};
        setup_next.neg     = neg_reg;
        setup_next.mag     = mag_reg;
        setup_next.mult    = scale ? duty_limit : LIM_W'(1);
        setup_next.divisor = scale ? peak : MAG_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            cmd_reg <= cmd_next;
        end
        if (ready2 && v1_reg)
        begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
        if (ready3 && v2_reg)
        begin
            setup_reg <= setup_next;
        end
    end

endmodule

// ----- rtl/core/mwm_scale_mul.sv -----
// ============================================================================
// mwm_scale_mul
// One pipeline stage that multiplies each wheel magnitude by the scale factor
// and loads the product into the divider format.
// ============================================================================
module mwm_scale_mul
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mwm_pkg::mwm_setup_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mwm_pkg::mwm_div_t   out_data
);
    import mwm_pkg::*;

    logic       valid_reg;
    mwm_div_t   data_reg;
    mwm_div_t   data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        logic [PROD_W-1:0] prod;
        data_next.neg     = in_data.neg;
        data_next.divisor = in_data.divisor;
        for (int i = 0; i < WHEELS; i++)
        begin
            prod = {{LIM_W{1'b0}}, in_data.mag[i]} * {{MAG_W{1'b0}}, in_data.mult};
            data_next.rem[i] = prod[PROD_W-1 -: MAG_W];
            data_next.low[i] = prod[QUO_W-1:0];
            data_next.quo[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/core/mwm_div_stage.sv -----
// ============================================================================
// mwm_div_stage
// One stage of the pipelined restoring divider. It retires three quotient
// bits for all four wheels against the shared divisor.
// ============================================================================
module mwm_div_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mwm_pkg::mwm_div_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mwm_pkg::mwm_div_t   out_data
);
    import mwm_pkg::*;

    logic       valid_reg;
    mwm_div_t   data_reg;
    mwm_div_t   data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        logic [MAG_W:0] trial;
        logic [MAG_W:0] dext;
        mag_t           r;
        quo_t           lo;
        quo_t           q;
        data_next.neg     = in_data.neg;
        data_next.divisor = in_data.divisor;
        dext = {1'b0, in_data.divisor};
        for (int w = 0; w < WHEELS; w++)
        begin
            r  = in_data.rem[w];
            lo = in_data.low[w];
            q  = in_data.quo[w];
            for (int s = 0; s < DIV_STEP; s++)
            begin
                trial = {r, lo[QUO_W-1]};
                lo    = {lo[QUO_W-2:0], 1'b0};
                if (trial >= dext)
                begin
                    trial = trial - dext;
                    q     = {q[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    q     = {q[QUO_W-2:0], 1'b0};
                end
                r = trial[MAG_W-1:0];
            end
            data_next.rem[w] = r;
            data_next.low[w] = lo;
            data_next.quo[w] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/core/mecanum_wheel_mixer.sv -----
// ============================================================================
// mecanum_wheel_mixer
// Mecanum inverse kinematics with peak normalization: clamps a motion
// command, mixes the four wheel values, scales them to the duty limit and
// gives a direction code and duty for every wheel.
// ============================================================================
//
// Channel   Dir  Signals                        Content
// s         in   s_tvalid s_tready s_tdata      forward, sideways, turn command
// m         out  m_tvalid m_tready m_tdata      dir and duty for four wheels
// cfg       in   cfg_we cfg_index cfg_data      command limit, duty limit
//
// Every stage holds one item, so one item enters per cycle unless m_tready
// stalls the pipe; each result passes through clamp, sums, peak search,
// multiply, five divider stages and the output register.
// Reset clears the valid bits of all stages and loads both limits with 999.
// A stall on m_tready backs up stage by stage; empty stages keep accepting.
//
module mecanum_wheel_mixer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // forward_speed, sideways_speed, turn_rate
    input  logic [mwm_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // front_left_dir, front_left_duty, front_right_dir, front_right_duty,
    // back_left_dir, back_left_duty, back_right_dir, back_right_duty, zero pad
    output logic [mwm_pkg::OUT_W-1:0]   m_tdata,
    input  logic                        cfg_we,
    input  logic [mwm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [mwm_pkg::LIM_W-1:0]   cfg_data
);
    import mwm_pkg::*;

    logic [LIM_W-1:0]       command_limit_reg;
    logic [LIM_W-1:0]       duty_limit_reg;
    logic                   front_valid;
    logic                   front_ready;
    mwm_setup_t             front_data;
    logic [DIV_STAGES:0]    div_valid;
    logic [DIV_STAGES:0]    div_ready;
    mwm_div_t               div_data [DIV_STAGES+1];
    logic                   out_ready;
    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;
    logic [OUT_W-1:0]       m_tdata_next;
    logic [WHEELS-1:0]      duty_ok;
    logic [WHEELS-1:0]      dir_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_limit_reg <= LIMIT_RESET;
            duty_limit_reg    <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COMMAND_LIMIT: command_limit_reg <= cfg_data;
                CFG_DUTY_LIMIT:    duty_limit_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    mwm_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_data       (s_tdata),
        .command_limit (command_limit_reg),
        .duty_limit    (duty_limit_reg),
        .out_valid     (front_valid),
        .out_ready     (front_ready),
        .out_data      (front_data)
    );

    mwm_scale_mul u_scale_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        mwm_div_stage u_div_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    assign out_ready             = !m_tvalid_reg || m_tready;
    assign div_ready[DIV_STAGES] = out_ready;

    always_comb
    begin
        quo_t duty;
        dir_t dir;
        m_tdata_next = '0;
        for (int w = 0; w < WHEELS; w++)
        begin
            duty = div_data[DIV_STAGES].quo[w];
            if (duty == '0)
            begin
                dir = DIR_OFF;
            end
            else if (div_data[DIV_STAGES].neg[w])
            begin
                dir = DIR_REV;
            end
            else
            begin
                dir = DIR_FWD;
            end
            m_tdata_next[w*FIELD_W +: FIELD_W] = {duty, dir};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            m_tvalid_reg <= div_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && div_valid[DIV_STAGES])
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        logic [DIR_W-1:0] d;
        quo_t             q;
        for (int w = 0; w < WHEELS; w++)
        begin
            d          = m_tdata_reg[w*FIELD_W +: DIR_W];
            q          = m_tdata_reg[w*FIELD_W + DIR_W +: QUO_W];
            duty_ok[w] = q <= duty_limit_reg;
            dir_ok[w]  = ((d == DIR_OFF) == (q == '0)) && (d != 2'd3);
        end
    end

    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (&duty_ok))
        else $error("wheel duty above duty limit");

    a_dir_matches_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (&dir_ok))
        else $error("direction code does not match duty");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register is empty");

endmodule
